// ===== hdl/lccu_pkg.sv =====
package lccu_pkg;

    // number width and derived digit budget (floor(W*log10(2)) + 1 decimal digits)
    localparam int NUMBER_WIDTH  = 64;
    localparam int NUM_DIGITS    = (NUMBER_WIDTH * 30103) / 100000 + 1;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = NUM_DIGITS * DIGIT_W;

    // conversion takes a few input bits per cycle
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = (NUMBER_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PAD_W         = CONV_STEPS * BITS_PER_STEP;

    // sequencer counter covers both phases
    localparam int MAX_STEPS     = (CONV_STEPS > NUM_DIGITS) ? CONV_STEPS : NUM_DIGITS;
    localparam int STEP_W        = $clog2(MAX_STEPS);
    localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
    localparam int COUNT_W       = $clog2(NUM_DIGITS + 1);

    // port field widths
    localparam int IN_DATA_W     = 64;
    localparam int CLASS_W       = 2;
    localparam int DCOUNT_W      = 5;
    localparam int OUT_DATA_W    = 8;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE,
        CLASS_FIVE_X,
        CLASS_THREE_X,
        CLASS_FOUR_X
    } issuer_class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CONV_HOLD,
        CONV_LOAD,
        CONV_DABBLE,
        CONV_SHIFT
    } conv_op_t;

    typedef struct packed {
        logic                 clear;
        logic                 step;
        logic [DIG_IDX_W-1:0] index;
    } scan_ctrl_t;

    typedef struct packed {
        logic               ok;
        issuer_class_t      cls;
        logic [COUNT_W-1:0] count;
    } luhn_result_t;

endpackage

// ===== hdl/lccu_bcd_conv.sv =====
module lccu_bcd_conv
(
    input  logic                            clk,
    input  lccu_pkg::conv_op_t              op,
    input  logic [lccu_pkg::NUMBER_WIDTH-1:0] number,
    output lccu_pkg::digit_t                digit
);
    import lccu_pkg::*;

    logic [PAD_W-1:0] bin_reg;
    logic [PAD_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;

    // shift-add-3 over a few input bits, msb first
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                input logic [BITS_PER_STEP-1:0] bits);
        logic [BCD_W-1:0] acc;
        digit_t           d;
        acc = bcd;
        for (int s = BITS_PER_STEP - 1; s >= 0; s--)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                d = acc[k*DIGIT_W +: DIGIT_W];
                if (d >= 4'd5)
                begin
                    acc[k*DIGIT_W +: DIGIT_W] = d + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[s]};
        end
        return acc;
    endfunction

    // operation select
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        unique case (op)
            CONV_HOLD:
            begin
                bin_next = bin_reg;
            end
            CONV_LOAD:
            begin
                bin_next = PAD_W'(number);
                bcd_next = '0;
            end
            CONV_DABBLE:
            begin
                bcd_next = dabble(bcd_reg, bin_reg[PAD_W-1 -: BITS_PER_STEP]);
                bin_next = {bin_reg[PAD_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            end
            CONV_SHIFT:
            begin
                bcd_next = {{DIGIT_W{1'b0}}, bcd_reg[BCD_W-1:DIGIT_W]};
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // least significant decimal digit out
    assign digit = bcd_reg[DIGIT_W-1:0];

endmodule

// ===== hdl/lccu_digit_acc.sv =====
module lccu_digit_acc
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lccu_pkg::scan_ctrl_t   ctrl,
    input  lccu_pkg::digit_t       digit,
    output lccu_pkg::luhn_result_t result
);
    import lccu_pkg::*;

    logic [3:0]         sum_reg;
    logic [3:0]         sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    digit_t             top_reg;
    digit_t             top_next;
    digit_t             second_reg;
    digit_t             second_next;
    digit_t             prev_reg;
    digit_t             prev_next;

    logic [4:0]         dbl;
    digit_t             folded;
    digit_t             term;
    logic [4:0]         sum_wide;
    logic               ok;
    issuer_class_t      cls;

    // luhn term: every second digit doubled and folded
    always_comb
    begin
        dbl      = {digit, 1'b0};
        folded   = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
        term     = ctrl.index[0] ? folded : digit;
        sum_wide = {1'b0, sum_reg} + {1'b0, term};
    end

    // running sum mod ten, digit count and leading two digits
    always_comb
    begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        second_next = second_reg;
        prev_next   = prev_reg;
        if (ctrl.clear)
        begin
            sum_next    = '0;
            count_next  = '0;
            top_next    = '0;
            second_next = '0;
            prev_next   = '0;
        end
        else if (ctrl.step)
        begin
            sum_next  = (sum_wide >= 5'd10) ? 4'(sum_wide - 5'd10) : sum_wide[3:0];
            prev_next = digit;
            if (digit != '0)
            begin
                count_next  = COUNT_W'(ctrl.index) + COUNT_W'(1);
                top_next    = digit;
                second_next = prev_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            count_reg  <= '0;
            top_reg    <= '0;
            second_reg <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            second_reg <= second_next;
            prev_reg   <= prev_next;
        end
    end

    // issuer class from checksum, length and prefix
    always_comb
    begin
        ok = (sum_reg == 4'd0);
        priority if (!ok)
        begin
            cls = CLASS_NONE;
        end
        else if ((32'(count_reg) == 32'd16) && (top_reg == 4'd5) &&
                 (second_reg >= 4'd1) && (second_reg <= 4'd5))
        begin
            cls = CLASS_FIVE_X;
        end
        else if ((32'(count_reg) == 32'd15) && (top_reg == 4'd3) &&
                 ((second_reg == 4'd4) || (second_reg == 4'd7)))
        begin
            cls = CLASS_THREE_X;
        end
        else if (((32'(count_reg) == 32'd16) || (32'(count_reg) == 32'd13)) &&
                 (top_reg == 4'd4))
        begin
            cls = CLASS_FOUR_X;
        end
        else
        begin
            cls = CLASS_NONE;
        end
    end

    assign result.ok    = ok;
    assign result.cls   = cls;
    assign result.count = count_reg;

endmodule

// ===== hdl/luhn_card_number_check_unit.sv =====
// Luhn card number checker. Each transfer on s_axis carries one card number as an unsigned
// binary value; each transfer on m_axis returns checksum_ok, issuer_class and digit_count for
// it, in order. Items are handled one at a time: the binary value is turned into decimal by a
// shift-add-3 unit that takes 4 bits per cycle, then one Luhn accumulator takes one decimal
// digit per cycle, and the result register is loaded once the output is free; only then is a
// new number taken. s_axis_tready is high only while the sequencer is idle; a result left
// waiting on m_axis does not block the next number until that number is ready to report.
module luhn_card_number_check_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lccu_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [63:0] card_number
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lccu_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [0] checksum_ok,
                                                            // [2:1] issuer_class,
                                                            // [7:3] digit_count
);
    import lccu_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_W-1:0]     step_cnt_reg;
    logic [STEP_W-1:0]     step_cnt_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [OUT_DATA_W-1:0] m_data_next;

    conv_op_t              conv_op;
    scan_ctrl_t            scan_ctrl;
    digit_t                digit;
    luhn_result_t          result;
    logic                  last_conv;
    logic                  last_scan;
    logic                  out_free;
    logic                  load_out;

    lccu_bcd_conv u_conv
    (
        .clk    (clk),
        .op     (conv_op),
        .number (s_axis_tdata[NUMBER_WIDTH-1:0]),
        .digit  (digit)
    );

    lccu_digit_acc u_acc
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .digit  (digit),
        .result (result)
    );

    assign last_conv = (step_cnt_reg == STEP_W'(CONV_STEPS - 1));
    assign last_scan = (step_cnt_reg == STEP_W'(NUM_DIGITS - 1));
    assign out_free  = !m_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (last_conv)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        conv_op       = CONV_HOLD;
        scan_ctrl     = '0;
        step_cnt_next = step_cnt_reg;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                step_cnt_next = '0;
                if (s_axis_tvalid)
                begin
                    conv_op         = CONV_LOAD;
                    scan_ctrl.clear = 1'b1;
                end
            end
            ST_CONV:
            begin
                conv_op       = CONV_DABBLE;
                step_cnt_next = last_conv ? '0 : step_cnt_reg + STEP_W'(1);
            end
            ST_SCAN:
            begin
                conv_op         = CONV_SHIFT;
                scan_ctrl.step  = 1'b1;
                scan_ctrl.index = step_cnt_reg[DIG_IDX_W-1:0];
                step_cnt_next   = step_cnt_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {DCOUNT_W'(result.count), result.cls, result.ok};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // an accepted number always starts conversion
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_CONV))
        else $error("accepted number did not start conversion");

    // a new result only follows the report state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the report state");

    // digit scan never runs past the last decimal digit
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (32'(step_cnt_reg) < NUM_DIGITS))
        else $error("digit index out of range");

    // reported digit count fits the digit budget
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[OUT_DATA_W-1:3]) <= NUM_DIGITS))
        else $error("digit count out of range");

    // a failed checksum never carries an issuer class
    a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == CLASS_NONE))
        else $error("issuer class set on failed checksum");

endmodule
